// ===== rtl/rtd_pkg.sv =====
package rtd_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int POS_FRAC_BITS_DEF = 16;
  localparam int CORDIC_MAX        = 24;

  localparam int NTERM  = 3;
  localparam int CS_W   = 33;
  localparam int Z_W    = 34;
  localparam int PROD_W = 66;
  localparam int TERM_W = 34;
  localparam int SUM_W  = 36;

  localparam logic [31:0] GOLDEN_Q30      = 32'd1737350766;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [1:0] LEN_ONE    = 2'd0;
  localparam logic [1:0] LEN_GOLDEN = 2'd1;
  localparam logic [1:0] LEN_SUM    = 2'd2;

  localparam logic KIND_FAT  = 1'b0;
  localparam logic KIND_THIN = 1'b1;

  typedef struct packed {
    logic               tile_kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
  } rtd_in_t;

  typedef struct packed {
    logic               child_kind;
    logic signed [31:0] child_x;
    logic signed [31:0] child_y;
    logic        [15:0] child_heading;
    logic               last_child;
  } rtd_out_t;

  // Per-child data that rides alongside the sine/cosine lanes.
  typedef struct packed {
    logic                        kind;
    logic [15:0]                 heading;
    logic                        last;
    logic signed [31:0]          pos_x;
    logic signed [31:0]          pos_y;
    logic [NTERM-1:0]            ena;
    logic [NTERM-1:0][1:0]       len;
  } rtd_side_t;

  typedef struct packed {
    logic                  kind;
    logic [3:0]            add;
    logic                  last;
    logic [NTERM-1:0]      ena;
    logic [NTERM-1:0][1:0] len;
    logic [NTERM-1:0][3:0] sub;
  } rtd_rule_t;

  function automatic logic [15:0] step36(input logic [3:0] m);
    logic [15:0] v;
    case (m)
      4'd0:    v = 16'd0;
      4'd1:    v = 16'd6554;
      4'd2:    v = 16'd13107;
      4'd3:    v = 16'd19661;
      4'd4:    v = 16'd26214;
      4'd5:    v = 16'd32768;
      4'd6:    v = 16'd39322;
      4'd7:    v = 16'd45875;
      4'd8:    v = 16'd52429;
      4'd9:    v = 16'd58982;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] atan_val(input int i);
    logic [31:0] v;
    case (i)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Deflation rules, indexed by parent kind and child number.
  function automatic rtd_rule_t rule(input logic thin, input logic [2:0] k);
    rtd_rule_t r;
    r = '0;
    case ({thin, k})
      {KIND_FAT, 3'd0}: begin
        r.kind = KIND_FAT;  r.add = 4'd5; r.ena = 3'b001;
        r.len[0] = LEN_SUM; r.sub[0] = 4'd1;
      end
      {KIND_FAT, 3'd1}: begin
        r.kind = KIND_FAT;  r.add = 4'd6; r.ena = 3'b001;
        r.len[0] = LEN_GOLDEN; r.sub[0] = 4'd0;
      end
      {KIND_FAT, 3'd2}: begin
        r.kind = KIND_FAT;  r.add = 4'd4; r.ena = 3'b001;
        r.len[0] = LEN_GOLDEN; r.sub[0] = 4'd2;
      end
      {KIND_FAT, 3'd3}: begin
        r.kind = KIND_THIN; r.add = 4'd1; r.ena = 3'b001;
        r.len[0] = LEN_ONE; r.sub[0] = 4'd1;
      end
      {KIND_FAT, 3'd4}: begin
        r.kind = KIND_THIN; r.add = 4'd3; r.ena = 3'b001; r.last = 1'b1;
        r.len[0] = LEN_SUM; r.sub[0] = 4'd2;
      end
      {KIND_THIN, 3'd0}: begin
        r.kind = KIND_FAT;  r.add = 4'd1; r.ena = 3'b000;
      end
      {KIND_THIN, 3'd1}: begin
        r.kind = KIND_FAT;  r.add = 4'd5; r.ena = 3'b011;
        r.len[0] = LEN_GOLDEN; r.sub[0] = 4'd0;
        r.len[1] = LEN_GOLDEN; r.sub[1] = 4'd1;
      end
      {KIND_THIN, 3'd2}: begin
        r.kind = KIND_THIN; r.add = 4'd7; r.ena = 3'b001;
        r.len[0] = LEN_GOLDEN; r.sub[0] = 4'd0;
      end
      {KIND_THIN, 3'd3}: begin
        r.kind = KIND_THIN; r.add = 4'd3; r.ena = 3'b111; r.last = 1'b1;
        r.len[0] = LEN_GOLDEN; r.sub[0] = 4'd0;
        r.len[1] = LEN_ONE;    r.sub[1] = 4'd2;
        r.len[2] = LEN_ONE;    r.sub[2] = 4'd3;
      end
      default: r.last = 1'b1;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/rtd_expand.sv =====
module rtd_expand (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rtd_pkg::rtd_in_t               in_data,
  output logic                           tok_valid,
  output rtd_pkg::rtd_side_t             tok_side,
  output logic [15:0]                    tok_ang [rtd_pkg::NTERM]
);

  logic               par_v_r;
  rtd_pkg::rtd_in_t   par_r;
  logic [2:0]         idx_r;
  logic               tok_v_r;
  rtd_pkg::rtd_side_t tok_side_r;
  logic [15:0]        tok_ang_r [rtd_pkg::NTERM];
  rtd_pkg::rtd_rule_t rl;
  logic               in_take;
  logic               emit_last;

  assign rl        = rtd_pkg::rule(par_r.tile_kind, idx_r);
  assign emit_last = par_v_r && en && rl.last;
  assign in_stall  = par_v_r && !(en && rl.last);
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_v_r <= 1'b0;
      idx_r   <= 3'd0;
      tok_v_r <= 1'b0;
    end else begin
      if (en) tok_v_r <= par_v_r;
      if (emit_last) begin
        par_v_r <= 1'b0;
        idx_r   <= 3'd0;
      end else if (par_v_r && en) begin
        idx_r <= idx_r + 3'd1;
      end
      if (in_take) par_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) par_r <= in_data;
    if (en) begin
      tok_side_r.kind    <= rl.kind;
      tok_side_r.heading <= par_r.heading + rtd_pkg::step36(rl.add);
      tok_side_r.last    <= rl.last;
      tok_side_r.pos_x   <= par_r.pos_x;
      tok_side_r.pos_y   <= par_r.pos_y;
      tok_side_r.ena     <= rl.ena;
      tok_side_r.len     <= rl.len;
      for (int t = 0; t < rtd_pkg::NTERM; t++) begin
        tok_ang_r[t] <= par_r.heading - rtd_pkg::step36(rl.sub[t]);
      end
    end
  end

  assign tok_valid = tok_v_r;
  assign tok_side  = tok_side_r;
  assign tok_ang   = tok_ang_r;

endmodule

// ===== rtl/rtd_cordic.sv =====
module rtd_cordic #(
  parameter int NIT = rtd_pkg::ANGLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [15:0]                       ang,
  output logic signed [rtd_pkg::CS_W-1:0]   cos_o,
  output logic signed [rtd_pkg::CS_W-1:0]   sin_o
);

  localparam int CW = rtd_pkg::CS_W;
  localparam int ZW = rtd_pkg::Z_W;

  logic signed [CW-1:0] x_r [NIT];
  logic signed [CW-1:0] y_r [NIT];
  logic signed [ZW-1:0] z_r [NIT];
  logic signed [CW-1:0] x_in [NIT];
  logic signed [CW-1:0] y_in [NIT];
  logic signed [ZW-1:0] z_in [NIT];

  logic [31:0]          z32;
  logic                 fold;
  logic signed [CW-1:0] k_pos;

  // Angles outside a quarter turn are brought in by a half-turn rotation,
  // which negates the start vector.
  assign z32   = {ang, 16'h0000};
  assign fold  = z32[31] ^ z32[30];
  assign k_pos = $signed({1'b0, rtd_pkg::CORDIC_GAIN_Q30});

  for (genvar i = 0; i < NIT; i++) begin : g_stage
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    if (i == 0) begin : g_first
      assign x_in[i] = fold ? -k_pos : k_pos;
      assign y_in[i] = '0;
      assign z_in[i] = ZW'($signed({z32[31] ^ fold, z32[30:0]}));
    end else begin : g_next
      assign x_in[i] = x_r[i-1];
      assign y_in[i] = y_r[i-1];
      assign z_in[i] = z_r[i-1];
    end
    assign dx = y_in[i] >>> i;
    assign dy = x_in[i] >>> i;
    assign at = $signed({{(ZW-32){1'b0}}, rtd_pkg::atan_val(i)});

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_in[i][ZW-1]) begin
          x_r[i] <= x_in[i] - dx;
          y_r[i] <= y_in[i] + dy;
          z_r[i] <= z_in[i] - at;
        end else begin
          x_r[i] <= x_in[i] + dx;
          y_r[i] <= y_in[i] - dy;
          z_r[i] <= z_in[i] + at;
        end
      end
    end
  end

  assign cos_o = x_r[NIT-1];
  assign sin_o = y_r[NIT-1];

endmodule

// ===== rtl/rtd_term.sv =====
module rtd_term #(
  parameter int POS_FRAC_BITS = rtd_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_v,
  input  rtd_pkg::rtd_side_t               side,
  input  logic signed [rtd_pkg::CS_W-1:0]  cos_i [rtd_pkg::NTERM],
  input  logic signed [rtd_pkg::CS_W-1:0]  sin_i [rtd_pkg::NTERM],
  output logic                             out_valid,
  output rtd_pkg::rtd_out_t                out_data
);

  localparam int CW = rtd_pkg::CS_W;
  localparam int PW = rtd_pkg::PROD_W;
  localparam int TW = rtd_pkg::TERM_W;
  localparam int SW = rtd_pkg::SUM_W;
  localparam int NT = rtd_pkg::NTERM;
  localparam int SH = 60 - POS_FRAC_BITS;

  localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

  logic signed [32:0] g_s;
  assign g_s = $signed({1'b0, rtd_pkg::GOLDEN_Q30});

  // Stage M: golden-ratio products.
  logic               m_v_r;
  rtd_pkg::rtd_side_t m_side_r;
  logic signed [CW-1:0] m_c_r [NT];
  logic signed [CW-1:0] m_s_r [NT];
  logic signed [PW-1:0] m_pc_r [NT];
  logic signed [PW-1:0] m_ps_r [NT];
  logic signed [63:0]   m_bx_r, m_by_r;

  // Stage R: rounded terms and scaled parent.
  logic               r_v_r;
  rtd_pkg::rtd_side_t r_side_r;
  logic signed [TW-1:0] r_tx_r [NT];
  logic signed [TW-1:0] r_ty_r [NT];
  logic signed [TW-1:0] r_bx_r, r_by_r;

  logic              out_v_r;
  rtd_pkg::rtd_out_t out_r;

  logic signed [SW-1:0] sum_x, sum_y;

  function automatic logic signed [TW-1:0] round_term(
    input logic signed [CW-1:0] cs,
    input logic signed [PW-1:0] pg,
    input logic [1:0]           len,
    input logic                 ena
  );
    logic signed [PW-1:0] unit;
    logic signed [PW-1:0] full;
    unit = PW'(cs) <<< 30;
    case (len)
      rtd_pkg::LEN_GOLDEN: full = pg;
      rtd_pkg::LEN_SUM:    full = unit + pg;
      default:             full = unit;
    endcase
    full = full + (PW'(1) <<< (SH - 1));
    full = full >>> SH;
    return ena ? TW'(full) : '0;
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    if (v > SAT_MAX)      c = SAT_MAX;
    else if (v < SAT_MIN) c = SAT_MIN;
    else                  c = v;
    return c[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      r_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      m_v_r   <= in_v;
      r_v_r   <= m_v_r;
      out_v_r <= r_v_r;
    end
  end

  always_comb begin
    sum_x = SW'(r_bx_r);
    sum_y = SW'(r_by_r);
    for (int t = 0; t < NT; t++) begin
      sum_x = sum_x + SW'(r_tx_r[t]);
      sum_y = sum_y + SW'(r_ty_r[t]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r <= side;
      m_bx_r   <= side.pos_x * g_s;
      m_by_r   <= side.pos_y * g_s;
      for (int t = 0; t < NT; t++) begin
        m_c_r[t]  <= cos_i[t];
        m_s_r[t]  <= sin_i[t];
        m_pc_r[t] <= cos_i[t] * g_s;
        m_ps_r[t] <= sin_i[t] * g_s;
      end

      r_side_r <= m_side_r;
      r_bx_r   <= TW'((m_bx_r + 64'sd536870912) >>> 30);
      r_by_r   <= TW'((m_by_r + 64'sd536870912) >>> 30);
      for (int t = 0; t < NT; t++) begin
        r_tx_r[t] <= round_term(m_c_r[t], m_pc_r[t], m_side_r.len[t], m_side_r.ena[t]);
        r_ty_r[t] <= round_term(m_s_r[t], m_ps_r[t], m_side_r.len[t], m_side_r.ena[t]);
      end

      out_r.child_kind    <= r_side_r.kind;
      out_r.child_x       <= sat(sum_x);
      out_r.child_y       <= sat(sum_y);
      out_r.child_heading <= r_side_r.heading;
      out_r.last_child    <= r_side_r.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/rhombus_tile_deflation.sv =====
// Latency: an accepted parent is held in the expander, which registers one token per child;
// each token passes the CORDIC stages and stages M and R of the term unit to the output register.
// Throughput: one child per cycle while the sink does not stall; a fat parent yields 5 children
// and a thin one 4, issued one at a time over the single result channel. The CORDIC lanes take one iteration per stage.
// Reset: synchronous, active low; it clears every valid bit and empties the pipeline.
module rhombus_tile_deflation #(
  parameter int ANGLE_BITS    = rtd_pkg::ANGLE_BITS_DEF,
  parameter int POS_FRAC_BITS = rtd_pkg::POS_FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtd_pkg::rtd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rtd_pkg::rtd_out_t out_data
);

  localparam int NIT = (ANGLE_BITS < rtd_pkg::CORDIC_MAX) ? ANGLE_BITS : rtd_pkg::CORDIC_MAX;
  localparam int NT  = rtd_pkg::NTERM;

  logic               en;
  logic               tok_valid;
  rtd_pkg::rtd_side_t tok_side;
  logic [15:0]        tok_ang [NT];
  logic signed [rtd_pkg::CS_W-1:0] cs [NT];
  logic signed [rtd_pkg::CS_W-1:0] sn [NT];

  logic               dv_r   [NIT];
  rtd_pkg::rtd_side_t side_r [NIT];

  // The whole pipeline advances unless a finished child is held by the sink.
  assign en = !out_valid || !out_stall;

  rtd_expand u_expand (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .tok_valid (tok_valid),
    .tok_side  (tok_side),
    .tok_ang   (tok_ang)
  );

  for (genvar t = 0; t < NT; t++) begin : g_lane
    rtd_cordic #(.NIT(NIT)) u_cordic (
      .clk   (clk),
      .en    (en),
      .ang   (tok_ang[t]),
      .cos_o (cs[t]),
      .sin_o (sn[t])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NIT; i++) dv_r[i] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= tok_valid;
      for (int i = 1; i < NIT; i++) dv_r[i] <= dv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= tok_side;
      for (int i = 1; i < NIT; i++) side_r[i] <= side_r[i-1];
    end
  end

  rtd_term #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_term (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (dv_r[NIT-1]),
    .side      (side_r[NIT-1]),
    .cos_i     (cs),
    .sin_i     (sn),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/rtd_checker.sv =====
module rtd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input rtd_pkg::rtd_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input rtd_pkg::rtd_out_t out_data
);

  // A held result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A held input beat keeps its contents until the block takes it.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // Both deflation rules end on a thin child.
  a_last_thin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_child |-> out_data.child_kind == rtd_pkg::KIND_THIN)
    else $error("last child is not thin");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind rhombus_tile_deflation rtd_checker u_rtd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/rhombus_tile_deflation_tb.sv =====
module rhombus_tile_deflation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 330;
  localparam int MAX_ERR_PRINT = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rtd_pkg::rtd_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rtd_pkg::rtd_out_t out_data;

  rtd_pkg::rtd_in_t tile_queue[$];
  rtd_pkg::rtd_out_t child_queue[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit no_idle = 1'b0;
  bit recv_hold = 1'b0;
  bit send_pause = 1'b0;
  bit in_taken = 1'b0;

  rhombus_tile_deflation uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    longint t[24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    return t[i];
  endfunction

  function automatic bit [15:0] turn_tenths(int m);
    bit [15:0] t[10] = '{0, 6554, 13107, 19661, 26214, 32768, 39322, 45875,
                         52429, 58982};
    return t[m];
  endfunction

  // Rotates the vector (gain, 0) to the given heading; cos and sin in Q30.
  task automatic sin_cos(input bit [15:0] ang, output longint c, output longint s);
    bit [31:0] z;
    longint x, y, zs, dx, dy;
    z = {ang, 16'h0};
    x = 652032874;
    y = 0;
    if (((z + 32'h40000000) & 32'h80000000) != 0) begin
      z = z + 32'h80000000;
      x = -x;
    end
    zs = longint'(signed'(z));
    for (int i = 0; i < 16; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (zs >= 0) begin
        x -= dx; y += dy; zs -= arctan_step(i);
      end else begin
        x += dx; y -= dy; zs += arctan_step(i);
      end
    end
    c = x;
    s = y;
  endtask

  function automatic longint length_q30(int l);
    case (l)
      0: return 1073741824;
      1: return 1737350766;
      default: return 64'd1073741824 + 64'd1737350766;
    endcase
  endfunction

  function automatic longint vec_term(longint len, longint cs);
    return floor_shr(len * cs + (64'sd1 << 43), 44);
  endfunction

  task automatic deflate_tile(input rtd_pkg::rtd_in_t t);
    // Per child: kind, heading step, term count, lengths, subtracted steps.
    int fk[5] = '{0, 0, 0, 1, 1};
    int fa[5] = '{5, 6, 4, 1, 3};
    int fl[5] = '{2, 1, 1, 0, 2};
    int fs[5] = '{1, 0, 2, 1, 2};
    int tk[4] = '{0, 0, 1, 1};
    int ta[4] = '{1, 5, 7, 3};
    int tn[4] = '{0, 2, 1, 3};
    int tl[4][3] = '{'{0, 0, 0}, '{1, 1, 0}, '{1, 0, 0}, '{1, 0, 0}};
    int ts[4][3] = '{'{0, 0, 0}, '{0, 1, 0}, '{0, 0, 0}, '{0, 2, 3}};
    longint bx, by, cx, cy, c, s;
    int n, nt, kd, ad, ln, sb;
    rtd_pkg::rtd_out_t o;
    bx = floor_shr(longint'(t.pos_x) * 1737350766 + (64'sd1 << 29), 30);
    by = floor_shr(longint'(t.pos_y) * 1737350766 + (64'sd1 << 29), 30);
    n = t.tile_kind ? 4 : 5;
    for (int k = 0; k < n; k++) begin
      cx = bx;
      cy = by;
      kd = t.tile_kind ? tk[k] : fk[k];
      ad = t.tile_kind ? ta[k] : fa[k];
      nt = t.tile_kind ? tn[k] : 1;
      for (int j = 0; j < nt; j++) begin
        ln = t.tile_kind ? tl[k][j] : fl[k];
        sb = t.tile_kind ? ts[k][j] : fs[k];
        sin_cos(t.heading - turn_tenths(sb), c, s);
        cx += vec_term(length_q30(ln), c);
        cy += vec_term(length_q30(ln), s);
      end
      o.child_kind = kd[0];
      o.child_x = 32'(clamp32(cx));
      o.child_y = 32'(clamp32(cy));
      o.child_heading = t.heading + turn_tenths(ad);
      o.last_child = (k == n - 1);
      child_queue = {child_queue, o};
    end
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF - $urandom_range(0, 200000);
      1: return 32'h80000000 + $urandom_range(0, 200000);
      2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  // Driver: a new beat is loaded only after the previous one was accepted.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (tile_queue.size() > 0 && !send_pause &&
            (no_idle || $urandom_range(0, 99) >= 13)) begin
          in_data <= tile_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= recv_hold || (!no_idle && $urandom_range(0, 99) < 13);
    end
  end

  // Expectations are pushed at the rising edge that accepts a parent, long
  // before the pipeline latency lets its first child out.
  always @(posedge clk) begin
    rtd_pkg::rtd_out_t exp_child;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) deflate_tile(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (child_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERR_PRINT)
          $display("unexpected child beat %h", out_data);
      end else begin
        exp_child = child_queue.pop_front();
        if (out_data !== exp_child) begin
          mismatches++;
          if (mismatches <= MAX_ERR_PRINT)
            $display("child mismatch: expected %h got %h", exp_child, out_data);
        end
      end
    end
  end

  initial begin
    rtd_pkg::rtd_in_t t;
    logic signed [31:0] ext[4] = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: both kinds at position extremes and heading wrap points.
    for (int i = 0; i < 20; i++) begin
      t.tile_kind = i[0];
      t.pos_x = ext[i % 4];
      t.pos_y = ext[(i / 2) % 4];
      case (i % 5)
        0: t.heading = 16'h0000;
        1: t.heading = 16'hFFFF;
        2: t.heading = 16'h4000;
        3: t.heading = 16'd6553;
        default: t.heading = 16'h8000;
      endcase
      tile_queue = {tile_queue, t};
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      t.tile_kind = 1'($urandom_range(0, 1));
      t.pos_x = rand_pos();
      t.pos_y = rand_pos();
      t.heading = 16'($urandom);
      tile_queue = {tile_queue, t};
      if (i == 100) begin
        // Let the queue feed a backlog while the receiver holds off.
        fork
          begin
            recv_hold = 1'b1;
            repeat (200) @(posedge clk);
            recv_hold = 1'b0;
          end
        join_none
      end
      if (i == 180) begin
        wait (tile_queue.size() == 0);
        send_pause = 1'b1;
        wait (!in_valid && child_queue.size() == 0);
        repeat (30) @(posedge clk);
        send_pause = 1'b0;
        no_idle = 1'b1;
      end
      if (i == 260) begin
        wait (tile_queue.size() == 0);
        no_idle = 1'b0;
      end
    end
    wait (tile_queue.size() == 0 && !in_valid && child_queue.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && child_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
